FILE: src/skht_pkg.sv
// Shared constants, types and arithmetic helpers for the scalar Kalman health tracker.
package skht_pkg;

  localparam int DATA_W     = 16;
  localparam int FRAC_W     = 12;
  localparam int ONE        = 1 << FRAC_W;

  localparam int OP_W       = 3;
  localparam int REL_W      = 13;
  localparam int STAMP_W    = 63;
  localparam int PN_W       = 13;
  localparam int THR_W      = 14;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;

  localparam int EST_N      = 4;
  localparam int SEL_W      = 2;
  localparam int VAR_W      = DATA_W - 1;
  localparam int R_W        = 14;
  localparam int DEN_W      = 16;
  localparam int GAIN_W     = FRAC_W + 1;
  localparam int MUL_AW     = DATA_W + 1;
  localparam int MUL_BW     = GAIN_W;
  localparam int MUL_PW     = MUL_AW + 1 + MUL_BW;
  localparam int RND_W      = MUL_PW + 1 - FRAC_W;
  localparam int SAT_W      = 24;
  localparam int OVER_W     = 19;
  localparam int STEP_CNT_W = $clog2(GAIN_W + 1);

  localparam logic [OP_W-1:0] OP_NONE  = 3'd0;
  localparam logic [OP_W-1:0] OP_MECH  = 3'd1;
  localparam logic [OP_W-1:0] OP_COOL  = 3'd2;
  localparam logic [OP_W-1:0] OP_POWER = 3'd3;
  localparam logic [OP_W-1:0] OP_LOAD  = 3'd4;

  localparam logic [SEL_W-1:0] EST_MECH  = 2'd0;
  localparam logic [SEL_W-1:0] EST_COOL  = 2'd1;
  localparam logic [SEL_W-1:0] EST_POWER = 2'd2;
  localparam logic [SEL_W-1:0] EST_LOAD  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_NOISE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NOISE_FLOOR   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOAD_THR      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COOL_THR      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_FACTOR    = 3'd4;

  localparam logic signed [DATA_W-1:0] EST_ONE_RST  = DATA_W'(ONE);
  localparam logic signed [DATA_W-1:0] EST_LOAD_RST = DATA_W'((ONE * 8 + 5) / 10);
  localparam logic [VAR_W-1:0]         VAR_RST      = VAR_W'(ONE / 2);
  localparam logic [VAR_W-1:0]         VAR_MAX      = {VAR_W{1'b1}};
  localparam logic [PN_W-1:0]          PN_RST       = PN_W'((ONE * 2 + 500) / 1000);
  localparam logic [PN_W-1:0]          NF_RST       = PN_W'((ONE + 50) / 100);
  localparam logic [THR_W-1:0]         LT_RST       = THR_W'((ONE * 7 + 5) / 10);
  localparam logic [THR_W-1:0]         CT_RST       = THR_W'((ONE * 8 + 5) / 10);
  localparam logic [PN_W-1:0]          MTF_RST      = PN_W'((ONE * 2 + 5) / 10);

  localparam logic signed [SAT_W-1:0] SAT_MAX = SAT_W'((64'sd1 <<< (DATA_W - 1)) - 64'sd1);
  localparam logic signed [SAT_W-1:0] SAT_MIN = SAT_W'(-(64'sd1 <<< (DATA_W - 1)));

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_MUL,
    ST_THR,
    ST_FAC,
    ST_EFF,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic in_ready;
    logic div_start;
    logic mul_start;
    logic eff_start;
    logic est_upd;
    logic thr_load;
    logic eff_upd;
    logic out_load;
  } ctl_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] mech_health;
    logic signed [DATA_W-1:0] cool_health;
    logic signed [DATA_W-1:0] power_avail;
    logic signed [DATA_W-1:0] load_estimate;
    logic signed [DATA_W-1:0] efficiency;
    logic [STAMP_W-1:0]       last_time;
  } out_word_t;

  // Clamp to the signed data range.
  function automatic logic signed [DATA_W-1:0] sat_d(input logic signed [SAT_W-1:0] v);
    logic signed [DATA_W-1:0] res;
    res = v[DATA_W-1:0];
    if (v > SAT_MAX) res = SAT_MAX[DATA_W-1:0];
    if (v < SAT_MIN) res = SAT_MIN[DATA_W-1:0];
    return res;
  endfunction

  // Drop the fraction bits of a product, rounding half up.
  function automatic logic signed [RND_W-1:0] rnd_q(input logic signed [MUL_PW-1:0] v);
    logic signed [MUL_PW:0] w;
    w = {v[MUL_PW-1], v} + (MUL_PW + 1)'(ONE / 2);
    return w[MUL_PW:FRAC_W];
  endfunction

endpackage

FILE: src/skht_if.sv
// Handshake channel interfaces for events, results and configuration writes.
interface skht_in_if;
  logic                                   valid;
  logic                                   ready;
  logic [skht_pkg::OP_W-1:0]              op;
  logic [skht_pkg::REL_W-1:0]             reliability;
  logic signed [skht_pkg::DATA_W-1:0]     severity;
  logic signed [skht_pkg::DATA_W-1:0]     load_value;
  logic                                   has_value;
  logic [skht_pkg::STAMP_W-1:0]           timestamp;

  modport source (output valid, op, reliability, severity, load_value, has_value, timestamp,
                  input ready);
  modport sink (input valid, op, reliability, severity, load_value, has_value, timestamp,
                output ready);
endinterface

interface skht_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [skht_pkg::DATA_W-1:0] mech_health;
  logic signed [skht_pkg::DATA_W-1:0] cool_health;
  logic signed [skht_pkg::DATA_W-1:0] power_avail;
  logic signed [skht_pkg::DATA_W-1:0] load_estimate;
  logic signed [skht_pkg::DATA_W-1:0] efficiency;
  logic [skht_pkg::STAMP_W-1:0]       last_time;

  modport source (output valid, mech_health, cool_health, power_avail, load_estimate,
                  efficiency, last_time, input ready);
  modport sink (input valid, mech_health, cool_health, power_avail, load_estimate,
                efficiency, last_time, output ready);
endinterface

interface skht_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [skht_pkg::CFG_IDX_W-1:0]     index;
  logic [skht_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: src/skht_div.sv
// Bit-serial restoring divider producing the Kalman gain P * 2^FRAC / (P + R).
module skht_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [skht_pkg::VAR_W-1:0]   num,
  input  logic [skht_pkg::DEN_W-1:0]   den,
  output logic                         busy,
  output logic [skht_pkg::GAIN_W-1:0]  quo
);

  logic [skht_pkg::STEP_CNT_W-1:0] cnt_r;
  logic [skht_pkg::DEN_W:0]        rem_r;
  logic [skht_pkg::DEN_W:0]        rem_nxt;
  logic [skht_pkg::DEN_W:0]        rem_sub;
  logic [skht_pkg::DEN_W-1:0]      den_r;
  logic [skht_pkg::GAIN_W-1:0]     quo_r;
  logic                            dz_r;
  logic                            ge;

  assign busy = (cnt_r != '0);

  // The numerator never exceeds the denominator, so the first step yields the integer bit.
  always_comb begin
    ge      = (rem_r >= {1'b0, den_r});
    rem_sub = ge ? (rem_r - {1'b0, den_r}) : rem_r;
    rem_nxt = {rem_sub[skht_pkg::DEN_W-1:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= skht_pkg::STEP_CNT_W'(skht_pkg::GAIN_W);
    end else if (busy) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= (skht_pkg::DEN_W + 1)'(num);
      den_r <= den;
      quo_r <= '0;
      dz_r  <= (den == '0);
    end else if (busy) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[skht_pkg::GAIN_W-2:0], ge};
    end
  end

  // A zero denominator means no information in the measurement: gain is zero.
  assign quo = dz_r ? '0 : quo_r;

endmodule

FILE: src/skht_mul.sv
// Bit-serial shift-add multiplier: signed multiplicand times unsigned multiplier.
module skht_mul (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [skht_pkg::MUL_AW-1:0]  a,
  input  logic [skht_pkg::MUL_BW-1:0]         b,
  output logic                                busy,
  output logic signed [skht_pkg::MUL_PW-1:0]  prod
);

  logic [skht_pkg::STEP_CNT_W-1:0]    cnt_r;
  logic signed [skht_pkg::MUL_AW-1:0] a_r;
  logic signed [skht_pkg::MUL_AW:0]   hi_r;
  logic [skht_pkg::MUL_BW-1:0]        lo_r;
  logic signed [skht_pkg::MUL_AW:0]   sum;

  assign busy = (cnt_r != '0);

  // One multiplier bit per cycle; the low half shifts out as the product's low bits.
  always_comb begin
    sum = hi_r + (lo_r[0] ? (skht_pkg::MUL_AW + 1)'(a_r) : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= skht_pkg::STEP_CNT_W'(skht_pkg::MUL_BW);
    end else if (busy) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r  <= a;
      hi_r <= '0;
      lo_r <= b;
    end else if (busy) begin
      hi_r <= {sum[skht_pkg::MUL_AW], sum[skht_pkg::MUL_AW:1]};
      lo_r <= {sum[0], lo_r[skht_pkg::MUL_BW-1:1]};
    end
  end

  assign prod = {hi_r, lo_r};

endmodule

FILE: src/scalar_kalman_health_tracker_unit.sv
// Top level of the four-channel scalar Kalman health tracker with efficiency derating.
//
// Channel  Dir  Word carried
// in_ch    in   op, reliability, severity, load_value, has_value, timestamp
// out_ch   out  mech_health, cool_health, power_avail, load_estimate, efficiency, last_time
// cfg_ch   in   index, data (process noise, noise floor, thresholds, minimum factor)
//
// An event with a measurement runs the serial gain divider, then the serial estimate and
// variance multipliers, then the serial efficiency multiply, plus setup. An event without
// a measurement skips the divider and the estimate and variance multiplies.
// Only one event is in flight; a new word is taken once the previous result is registered,
// even while that result still waits on out_ch. Synchronous active-low reset restores the
// initial estimates, variances and register defaults. Configuration is always ready.
module scalar_kalman_health_tracker_unit (
  input  logic        clk,
  input  logic        rst_n,
  skht_in_if.sink     in_ch,
  skht_out_if.source  out_ch,
  skht_cfg_if.sink    cfg_ch
);

  skht_pkg::state_t state_r;
  skht_pkg::state_t state_nxt;
  skht_pkg::ctl_t   ctl;

  // Configuration registers.
  logic [skht_pkg::PN_W-1:0]  pn_r;
  logic [skht_pkg::PN_W-1:0]  nf_r;
  logic [skht_pkg::THR_W-1:0] lt_r;
  logic [skht_pkg::THR_W-1:0] ct_r;
  logic [skht_pkg::PN_W-1:0]  mtf_r;

  // Tracker state.
  logic signed [skht_pkg::DATA_W-1:0] est_r [skht_pkg::EST_N];
  logic [skht_pkg::VAR_W-1:0]         var_r [skht_pkg::EST_N];
  logic signed [skht_pkg::DATA_W-1:0] eff_r;
  logic [skht_pkg::STAMP_W-1:0]       stamp_r;

  // Per-event operands.
  logic                               fuse_r;
  logic [skht_pkg::SEL_W-1:0]         sel_r;
  logic signed [skht_pkg::DATA_W-1:0] z_r;
  logic [skht_pkg::R_W-1:0]           r_r;
  logic                               derate_r;
  logic signed [skht_pkg::OVER_W-1:0] over_r;
  logic signed [skht_pkg::DATA_W-1:0] cap_r;

  skht_pkg::out_word_t out_r;
  logic                out_valid_r;

  logic                               accept;
  logic                               fuse_in;
  logic [skht_pkg::SEL_W-1:0]         sel_in;
  logic signed [skht_pkg::DATA_W:0]   z_ext;
  logic signed [skht_pkg::DATA_W-1:0] z_in;
  logic signed [skht_pkg::R_W+1:0]    r_ext;
  logic [skht_pkg::R_W-1:0]           r_in;
  logic [skht_pkg::VAR_W:0]           var_sum [skht_pkg::EST_N];
  logic [skht_pkg::VAR_W-1:0]         var_grow [skht_pkg::EST_N];

  logic [skht_pkg::VAR_W-1:0]         p_sel;
  logic signed [skht_pkg::DATA_W-1:0] est_sel;
  logic [skht_pkg::DEN_W-1:0]         den;
  logic                               div_busy;
  logic [skht_pkg::GAIN_W-1:0]        div_k;

  logic signed [skht_pkg::MUL_AW-1:0] est_diff;
  logic signed [skht_pkg::MUL_AW-1:0] mul0_a;
  logic [skht_pkg::MUL_BW-1:0]        mul0_b;
  logic                               mul0_busy;
  logic signed [skht_pkg::MUL_PW-1:0] mul0_prod;
  logic signed [skht_pkg::MUL_AW-1:0] mul1_a;
  logic [skht_pkg::MUL_BW-1:0]        mul1_b;
  logic                               mul1_busy;
  logic signed [skht_pkg::MUL_PW-1:0] mul1_prod;

  logic signed [skht_pkg::RND_W-1:0]  var_rnd;
  logic [skht_pkg::VAR_W-1:0]         var_fused;
  logic signed [skht_pkg::DATA_W-1:0] est_fused;
  logic signed [skht_pkg::SAT_W-1:0]  over_full;
  logic signed [skht_pkg::OVER_W-1:0] fac_s;
  logic [skht_pkg::GAIN_W-1:0]        fac;

  assign accept       = in_ch.valid && ctl.in_ready;
  assign in_ch.ready  = ctl.in_ready;
  assign cfg_ch.ready = 1'b1;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      skht_pkg::ST_IDLE: if (in_ch.valid) state_nxt = skht_pkg::ST_PREP;
      skht_pkg::ST_PREP: state_nxt = fuse_r ? skht_pkg::ST_DIV : skht_pkg::ST_THR;
      skht_pkg::ST_DIV:  if (!div_busy) state_nxt = skht_pkg::ST_MUL;
      skht_pkg::ST_MUL:  if (!mul0_busy) state_nxt = skht_pkg::ST_THR;
      skht_pkg::ST_THR:  state_nxt = skht_pkg::ST_FAC;
      skht_pkg::ST_FAC:  state_nxt = skht_pkg::ST_EFF;
      skht_pkg::ST_EFF:  if (!mul0_busy) state_nxt = skht_pkg::ST_FIN;
      skht_pkg::ST_FIN:  if (!out_valid_r || out_ch.ready) state_nxt = skht_pkg::ST_IDLE;
      default:           state_nxt = skht_pkg::ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    ctl = '0;
    case (state_r)
      skht_pkg::ST_IDLE: ctl.in_ready  = 1'b1;
      skht_pkg::ST_PREP: ctl.div_start = fuse_r;
      skht_pkg::ST_DIV:  ctl.mul_start = !div_busy;
      skht_pkg::ST_MUL:  ctl.est_upd   = !mul0_busy;
      skht_pkg::ST_THR:  ctl.thr_load  = 1'b1;
      skht_pkg::ST_FAC:  ctl.eff_start = 1'b1;
      skht_pkg::ST_EFF:  ctl.eff_upd   = !mul0_busy;
      skht_pkg::ST_FIN:  ctl.out_load  = !out_valid_r || out_ch.ready;
      default:           ctl = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= skht_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pn_r  <= skht_pkg::PN_RST;
      nf_r  <= skht_pkg::NF_RST;
      lt_r  <= skht_pkg::LT_RST;
      ct_r  <= skht_pkg::CT_RST;
      mtf_r <= skht_pkg::MTF_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        skht_pkg::CFG_PROCESS_NOISE: pn_r  <= cfg_ch.data[skht_pkg::PN_W-1:0];
        skht_pkg::CFG_NOISE_FLOOR:   nf_r  <= cfg_ch.data[skht_pkg::PN_W-1:0];
        skht_pkg::CFG_LOAD_THR:      lt_r  <= cfg_ch.data[skht_pkg::THR_W-1:0];
        skht_pkg::CFG_COOL_THR:      ct_r  <= cfg_ch.data[skht_pkg::THR_W-1:0];
        skht_pkg::CFG_MIN_FACTOR:    mtf_r <= cfg_ch.data[skht_pkg::PN_W-1:0];
        default: ;
      endcase
    end
  end

  // Event decode: which estimate to fuse, the measurement, its noise and the grown variances.
  always_comb begin
    fuse_in = 1'b0;
    sel_in  = skht_pkg::EST_MECH;
    case (in_ch.op)
      skht_pkg::OP_MECH:  begin fuse_in = 1'b1;            sel_in = skht_pkg::EST_MECH;  end
      skht_pkg::OP_COOL:  begin fuse_in = 1'b1;            sel_in = skht_pkg::EST_COOL;  end
      skht_pkg::OP_POWER: begin fuse_in = 1'b1;            sel_in = skht_pkg::EST_POWER; end
      skht_pkg::OP_LOAD:  begin fuse_in = in_ch.has_value; sel_in = skht_pkg::EST_LOAD;  end
      default: begin
        fuse_in = 1'b0;
        sel_in  = skht_pkg::EST_MECH;
      end
    endcase
    z_ext = (skht_pkg::DATA_W + 1)'(skht_pkg::ONE) - (skht_pkg::DATA_W + 1)'(in_ch.severity);
    if (in_ch.op == skht_pkg::OP_LOAD) begin
      z_in = in_ch.load_value;
    end else begin
      z_in = skht_pkg::sat_d(skht_pkg::SAT_W'(z_ext));
    end
    r_ext = (skht_pkg::R_W + 2)'(skht_pkg::ONE) - (skht_pkg::R_W + 2)'(in_ch.reliability)
            + (skht_pkg::R_W + 2)'(nf_r);
    r_in  = r_ext[skht_pkg::R_W+1] ? '0 : r_ext[skht_pkg::R_W-1:0];
    for (int i = 0; i < skht_pkg::EST_N; i++) begin
      var_sum[i]  = (skht_pkg::VAR_W + 1)'(var_r[i]) + (skht_pkg::VAR_W + 1)'(pn_r);
      var_grow[i] = var_sum[i][skht_pkg::VAR_W] ? skht_pkg::VAR_MAX
                                                : var_sum[i][skht_pkg::VAR_W-1:0];
    end
  end

  // Gain divider operands.
  assign p_sel   = var_r[sel_r];
  assign est_sel = est_r[sel_r];
  assign den     = skht_pkg::DEN_W'(p_sel) + skht_pkg::DEN_W'(r_r);

  skht_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ctl.div_start),
    .num   (p_sel),
    .den   (den),
    .busy  (div_busy),
    .quo   (div_k)
  );

  // Multiplier 0 does K*(z - est), then the efficiency product; multiplier 1 does P*(1 - K).
  always_comb begin
    est_diff = skht_pkg::MUL_AW'(z_r) - skht_pkg::MUL_AW'(est_sel);
    fac_s    = skht_pkg::OVER_W'(skht_pkg::ONE) - over_r;
    if (!derate_r) begin
      fac = skht_pkg::GAIN_W'(skht_pkg::ONE);
    end else if (fac_s < $signed(skht_pkg::OVER_W'(mtf_r))) begin
      fac = mtf_r;
    end else begin
      fac = fac_s[skht_pkg::GAIN_W-1:0];
    end
    if (state_r == skht_pkg::ST_FAC) begin
      mul0_a = skht_pkg::MUL_AW'(cap_r);
      mul0_b = fac;
    end else begin
      mul0_a = est_diff;
      mul0_b = div_k;
    end
    mul1_a = $signed(skht_pkg::MUL_AW'(p_sel));
    mul1_b = skht_pkg::GAIN_W'(skht_pkg::ONE) - div_k;
  end

  skht_mul u_mul_est (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ctl.mul_start || ctl.eff_start),
    .a     (mul0_a),
    .b     (mul0_b),
    .busy  (mul0_busy),
    .prod  (mul0_prod)
  );

  skht_mul u_mul_var (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ctl.mul_start),
    .a     (mul1_a),
    .b     (mul1_b),
    .busy  (mul1_busy),
    .prod  (mul1_prod)
  );

  always_comb begin
    est_fused = skht_pkg::sat_d(skht_pkg::SAT_W'(est_sel)
                                + skht_pkg::SAT_W'(skht_pkg::rnd_q(mul0_prod)));
    var_rnd   = skht_pkg::rnd_q(mul1_prod);
    if (var_rnd[skht_pkg::RND_W-1]) begin
      var_fused = '0;
    end else if (var_rnd > $signed(skht_pkg::RND_W'(skht_pkg::VAR_MAX))) begin
      var_fused = skht_pkg::VAR_MAX;
    end else begin
      var_fused = var_rnd[skht_pkg::VAR_W-1:0];
    end
    over_full = skht_pkg::SAT_W'(est_r[skht_pkg::EST_LOAD]) - $signed(skht_pkg::SAT_W'(lt_r))
                + $signed(skht_pkg::SAT_W'(ct_r)) - skht_pkg::SAT_W'(est_r[skht_pkg::EST_COOL]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      est_r[skht_pkg::EST_MECH]  <= skht_pkg::EST_ONE_RST;
      est_r[skht_pkg::EST_COOL]  <= skht_pkg::EST_ONE_RST;
      est_r[skht_pkg::EST_POWER] <= skht_pkg::EST_ONE_RST;
      est_r[skht_pkg::EST_LOAD]  <= skht_pkg::EST_LOAD_RST;
      for (int i = 0; i < skht_pkg::EST_N; i++) begin
        var_r[i] <= skht_pkg::VAR_RST;
      end
      eff_r   <= skht_pkg::EST_ONE_RST;
      stamp_r <= '0;
    end else begin
      if (accept) begin
        for (int i = 0; i < skht_pkg::EST_N; i++) begin
          var_r[i] <= var_grow[i];
        end
        stamp_r <= in_ch.timestamp;
      end
      if (ctl.est_upd) begin
        est_r[sel_r] <= est_fused;
        var_r[sel_r] <= var_fused;
      end
      if (ctl.eff_upd) begin
        eff_r <= skht_pkg::sat_d(skht_pkg::SAT_W'(skht_pkg::rnd_q(mul0_prod)));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fuse_r <= fuse_in;
      sel_r  <= sel_in;
      z_r    <= z_in;
      r_r    <= r_in;
    end
    // Derating applies only when load is high and cooling is weak at the same time.
    if (ctl.thr_load) begin
      derate_r <= (skht_pkg::SAT_W'(est_r[skht_pkg::EST_LOAD]) > $signed(skht_pkg::SAT_W'(lt_r)))
               && (skht_pkg::SAT_W'(est_r[skht_pkg::EST_COOL]) < $signed(skht_pkg::SAT_W'(ct_r)));
      over_r   <= over_full[skht_pkg::OVER_W-1:0];
      cap_r    <= (est_r[skht_pkg::EST_MECH] < est_r[skht_pkg::EST_POWER])
                  ? est_r[skht_pkg::EST_MECH] : est_r[skht_pkg::EST_POWER];
    end
    if (ctl.out_load) begin
      out_r.mech_health   <= est_r[skht_pkg::EST_MECH];
      out_r.cool_health   <= est_r[skht_pkg::EST_COOL];
      out_r.power_avail   <= est_r[skht_pkg::EST_POWER];
      out_r.load_estimate <= est_r[skht_pkg::EST_LOAD];
      out_r.efficiency    <= eff_r;
      out_r.last_time     <= stamp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.mech_health   = out_r.mech_health;
  assign out_ch.cool_health   = out_r.cool_health;
  assign out_ch.power_avail   = out_r.power_avail;
  assign out_ch.load_estimate = out_r.load_estimate;
  assign out_ch.efficiency    = out_r.efficiency;
  assign out_ch.last_time     = out_r.last_time;

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == skht_pkg::ST_PREP)
    else $error("accepted word did not start processing");

  a_div_before_mul: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == skht_pkg::ST_MUL |-> !div_busy && !(mul0_busy ^ mul1_busy))
    else $error("multipliers out of step with divider");

  a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.est_upd |-> div_k <= skht_pkg::GAIN_W'(skht_pkg::ONE))
    else $error("gain above one");

  a_div_only_fuse: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == skht_pkg::ST_DIV |-> fuse_r)
    else $error("divider run for an event without a measurement");

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == skht_pkg::ST_FIN))
    else $error("result posted outside the finish step");

endmodule
